// ===== sv/rspd_pkg.sv =====
// ============================================================================
// rspd_pkg: shared types and constants of the serial packet deframer
// Header bytes, phase codes, frame status codes and the result record.
// ============================================================================
package rspd_pkg;

	localparam logic [7:0] HDR_FIRST      = 8'hFA;
	localparam logic [7:0] HDR_SECOND     = 8'hFB;
	localparam logic [7:0] MIN_FRAME_LEN  = 8'd2;
	localparam logic [7:0] MAX_LEN_RESET  = 8'd204;

	// Phase codes of the frame state machine
	localparam logic [2:0] PH_HUNT_A  = 3'd0;
	localparam logic [2:0] PH_HUNT_B  = 3'd1;
	localparam logic [2:0] PH_LEN     = 3'd2;
	localparam logic [2:0] PH_PAYLOAD = 3'd3;
	localparam logic [2:0] PH_CK_HI   = 3'd4;
	localparam logic [2:0] PH_CK_LO   = 3'd5;

	// Frame end status codes
	localparam logic [1:0] ST_CK_GOOD = 2'd0;
	localparam logic [1:0] ST_CK_BAD  = 2'd1;
	localparam logic [1:0] ST_BAD_LEN = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] byte_index;
		logic       is_end;
		logic [1:0] frame_status;
	} result_t;

endpackage

// ===== sv/rspd_if.sv =====
// ============================================================================
// rspd_if: handshake channels of the serial packet deframer
// Received byte channel and result channel, each with valid/ready.
// ============================================================================
interface rspd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rspd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [7:0] byte_index;
	logic       is_end;
	logic [1:0] frame_status;

	modport source (output valid, output data_byte, output byte_index,
		output is_end, output frame_status, input ready);
	modport sink   (input valid, input data_byte, input byte_index,
		input is_end, input frame_status, output ready);
endinterface

// ===== sv/rspd_frame_ctrl.sv =====
// ============================================================================
// rspd_frame_ctrl: frame state machine and checksum accumulator
// Consumes one byte per step, updates the frame state and forms the result.
// ============================================================================
module rspd_frame_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             rx_byte,
	input  logic [7:0]             max_len,
	output logic                   res_valid,
	output rspd_pkg::result_t      res
);

	logic [2:0]  phase_q,      phase_d;
	logic [7:0]  remain_q,     remain_d;
	logic [7:0]  pos_q,        pos_d;
	logic [15:0] sum_q,        sum_d;
	logic [7:0]  held_q,       held_d;
	logic        odd_q,        odd_d;
	logic [7:0]  ck_hi_q,      ck_hi_d;
	logic [15:0] expect_sum;
	logic [7:0]  remain_dec;

	assign remain_dec = remain_q - 8'd1;
	assign expect_sum = sum_q ^ (odd_q ? {8'h00, held_q} : 16'h0000);

	always_comb begin
		phase_d   = phase_q;
		remain_d  = remain_q;
		pos_d     = pos_q;
		sum_d     = sum_q;
		held_d    = held_q;
		odd_d     = odd_q;
		ck_hi_d   = ck_hi_q;
		res_valid = 1'b0;
		res       = '0;
		case (phase_q)
			rspd_pkg::PH_HUNT_A: begin
				if (rx_byte == rspd_pkg::HDR_FIRST) phase_d = rspd_pkg::PH_HUNT_B;
			end
			rspd_pkg::PH_HUNT_B: begin
				if (rx_byte == rspd_pkg::HDR_SECOND) phase_d = rspd_pkg::PH_LEN;
				else if (rx_byte != rspd_pkg::HDR_FIRST) phase_d = rspd_pkg::PH_HUNT_A;
			end
			rspd_pkg::PH_LEN: begin
				if (rx_byte < rspd_pkg::MIN_FRAME_LEN || rx_byte > max_len) begin
					phase_d          = rspd_pkg::PH_HUNT_A;
					res_valid        = 1'b1;
					res.is_end       = 1'b1;
					res.frame_status = rspd_pkg::ST_BAD_LEN;
				end else begin
					remain_d = rx_byte - rspd_pkg::MIN_FRAME_LEN;
					pos_d    = 8'd0;
					sum_d    = 16'h0000;
					held_d   = 8'h00;
					odd_d    = 1'b0;
					phase_d  = (rx_byte == rspd_pkg::MIN_FRAME_LEN) ?
						rspd_pkg::PH_CK_HI : rspd_pkg::PH_PAYLOAD;
				end
			end
			rspd_pkg::PH_PAYLOAD: begin
				// pair bytes into big-endian words
				if (odd_q) begin
					sum_d = sum_q + {held_q, rx_byte};
					odd_d = 1'b0;
				end else begin
					held_d = rx_byte;
					odd_d  = 1'b1;
				end
				pos_d    = pos_q + 8'd1;
				remain_d = remain_dec;
				if (remain_dec == 8'd0) phase_d = rspd_pkg::PH_CK_HI;
				res_valid      = 1'b1;
				res.data_byte  = rx_byte;
				res.byte_index = pos_q;
			end
			rspd_pkg::PH_CK_HI: begin
				ck_hi_d = rx_byte;
				phase_d = rspd_pkg::PH_CK_LO;
			end
			rspd_pkg::PH_CK_LO: begin
				phase_d          = rspd_pkg::PH_HUNT_A;
				res_valid        = 1'b1;
				res.is_end       = 1'b1;
				res.frame_status = (expect_sum == {ck_hi_q, rx_byte}) ?
					rspd_pkg::ST_CK_GOOD : rspd_pkg::ST_CK_BAD;
			end
			default: begin
				phase_d = rspd_pkg::PH_HUNT_A;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= rspd_pkg::PH_HUNT_A;
			remain_q <= 8'd0;
			pos_q    <= 8'd0;
			sum_q    <= 16'h0000;
			held_q   <= 8'h00;
			odd_q    <= 1'b0;
			ck_hi_q  <= 8'h00;
		end else if (step) begin
			phase_q  <= phase_d;
			remain_q <= remain_d;
			pos_q    <= pos_d;
			sum_q    <= sum_d;
			held_q   <= held_d;
			odd_q    <= odd_d;
			ck_hi_q  <= ck_hi_d;
		end
	end

endmodule

// ===== sv/robot_serial_packet_deframer.sv =====
// ============================================================================
// robot_serial_packet_deframer: header/length framed serial packet deframer
// Hunts for the 0xFA 0xFB header, checks the length byte, emits payload
// bytes with their index and closes each frame with a checksum status.
// ============================================================================
//
//  Channel     Dir  Transaction                     Payload
//  ---------   ---  ------------------------------  ------------------------------
//  rx          in   one received serial byte        rx_byte
//  result      out  payload byte or frame end       data_byte, byte_index,
//                                                    is_end, frame_status
//  cfg_wr_*    in   write of max_frame_length        cfg_wr_data
//
//  Throughput is one byte per cycle while results are taken as offered. An
//  rx transaction loads the input register; the frame state machine then
//  consumes the byte and loads any result into the output register.
//  Reset (arst_n low) returns to header hunt, max_frame_length to 204.
//  A stalled result holds the output register; bytes that give no result
//  keep advancing, and a byte that gives a result waits in the input
//  register with rx.ready low until the result moves.
//
module robot_serial_packet_deframer (
	input  logic                 clk,
	input  logic                 arst_n,
	rspd_byte_if.sink            rx,
	rspd_result_if.source        result,
	input  logic                 cfg_wr_en,
	input  logic [7:0]           cfg_wr_data
);

	// Configuration register
	logic [7:0] max_len_q;

	// Input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Output register
	logic                  out_valid_q;
	rspd_pkg::result_t     out_q;

	logic                  res_valid;
	rspd_pkg::result_t     res;
	logic                  out_free;
	logic                  s1_go;
	logic                  step;

	// Output register can load when empty or being drained this cycle
	assign out_free = !out_valid_q || result.ready;
	// Stage 1 advances unless it has a result and the output is blocked
	assign s1_go    = !res_valid || out_free;
	assign step     = valid_s1 && s1_go;
	assign rx.ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= rspd_pkg::MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	// Hold the byte while stage 1 stalls; load a new one on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	rspd_frame_ctrl u_frame_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (byte_s1),
		.max_len   (max_len_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// Advance the result into the output register; drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && res_valid) begin
			out_q <= res;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.data_byte    = out_q.data_byte;
	assign result.byte_index   = out_q.byte_index;
	assign result.is_end       = out_q.is_end;
	assign result.frame_status = out_q.frame_status;

endmodule
